[rtl/bvp_pkg.sv]
// Shared types, constants and step functions of the ball velocity predictor.
`timescale 1ns / 1ps

package bvp_pkg;

  // pipeline layout: front end, drop divider, scaling back end
  localparam int F_STG   = 4;
  localparam int C_FIRST = F_STG;
  localparam int C_STG   = 8;
  localparam int C_BITS  = 4;
  localparam int S_FIRST = C_FIRST + C_STG;
  localparam int S_DIV   = 8;
  localparam int S_BITS  = 2;
  localparam int S_LEN   = S_DIV + 3;
  localparam int NSTG    = S_FIRST + S_LEN;

  // 10^6 / 2^6: the drop divider works on values already scaled by 2^10 or 2^-6
  localparam logic [14:0] DROP_DIV = 15'd15625;

  typedef enum logic [2:0] {
    REG_VEL_X  = 3'd0,
    REG_VEL_Y  = 3'd1,
    REG_SLIDE  = 3'd2,
    REG_ROLL   = 3'd3,
    REG_THRESH = 3'd4
  } reg_idx_t;

  // settled configuration plus values derived from it by the setup sequencer
  typedef struct packed {
    logic [1:0][15:0] mag;     // |vel_x|, |vel_y|
    logic [1:0]       neg;     // sign of vel_x, vel_y
    logic [15:0]      slide;
    logic [15:0]      roll;
    logic [30:0]      tq;      // threshold, Q.16
    logic [31:0]      sq;      // initial speed, Q.16
    logic [45:0]      yp;      // (sq - tq) * 15625
    logic [39:0]      c;       // ceil((sq - tq) * 10^6 / slide)
    logic             sq_zero;
    logic             rolling; // sq <= tq
  } cfg_t;

  // one restoring step of the divide by 15625: {quotient bit, remainder}
  function automatic logic [14:0] cdiv_step(input logic [13:0] r, input logic b);
    logic [14:0] x;
    x = {r, b};
    if (x >= DROP_DIV) begin
      return {1'b1, 14'(x - DROP_DIV)};
    end
    return {1'b0, x[13:0]};
  endfunction

  // one restoring step of the divide by the speed: {quotient bit, remainder}
  function automatic logic [32:0] sdiv_step(input logic [31:0] r, input logic b,
                                            input logic [31:0] d);
    logic [32:0] x;
    x = {r, b};
    if (x >= {1'b0, d}) begin
      return {1'b1, 32'(x - {1'b0, d})};
    end
    return {1'b0, x[31:0]};
  endfunction

endpackage

[rtl/bvp_setup.sv]
// Register file and setup sequencer: speed square root and sliding offset divide.
`timescale 1ns / 1ps

module bvp_setup (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output bvp_pkg::cfg_t      cfg,
  output logic               busy
);

  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 52;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_SQR  = 8'b00000010,
    ST_SUM  = 8'b00000100,
    ST_ROOT = 8'b00001000,
    ST_GAP  = 8'b00010000,
    ST_MUL  = 8'b00100000,
    ST_DIV  = 8'b01000000,
    ST_FIN  = 8'b10000000
  } state_t;

  state_t      state;
  logic [5:0]  cnt;
  logic [15:0] vel_x, vel_y, slide, roll;
  logic [14:0] thresh;
  logic        wr;

  logic [15:0] mag_x, mag_y;
  logic [30:0] tq;
  logic [31:0] sqx, sqy, root, gap, sq;
  logic [63:0] nrad;
  logic [32:0] rrem;
  logic [34:0] rcat, trial;
  logic        take;
  logic [51:0] dq;
  logic [15:0] drem;
  logic [16:0] dx;
  logic        dtake;
  logic [45:0] prod, yp;
  logic [39:0] cc;
  logic        sq_zero, rolling;

  assign wr    = psel & penable & pwrite;
  assign mag_x = vel_x[15] ? 16'(16'd0 - vel_x) : vel_x;
  assign mag_y = vel_y[15] ? 16'(16'd0 - vel_y) : vel_y;
  assign tq    = {thresh, 16'd0};
  assign busy  = (state != ST_IDLE);

  // integer square root, two radicand bits a step
  assign rcat  = {rrem, nrad[63:62]};
  assign trial = {1'b0, root, 2'b01};
  assign take  = (rcat >= trial);

  assign dx    = {drem, dq[51]};
  assign dtake = (dx >= {1'b0, slide});
  assign prod  = {14'd0, gap} * {32'd0, bvp_pkg::DROP_DIV[13:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_SQR;
      cnt    <= '0;
      vel_x  <= '0;
      vel_y  <= '0;
      slide  <= '0;
      roll   <= '0;
      thresh <= '0;
    end else begin
      if (wr) begin
        case (bvp_pkg::reg_idx_t'(paddr[4:2]))
          bvp_pkg::REG_VEL_X:  vel_x  <= pwdata[15:0];
          bvp_pkg::REG_VEL_Y:  vel_y  <= pwdata[15:0];
          bvp_pkg::REG_SLIDE:  slide  <= pwdata[15:0];
          bvp_pkg::REG_ROLL:   roll   <= pwdata[15:0];
          bvp_pkg::REG_THRESH: thresh <= pwdata[14:0];
          default: ;
        endcase
        state <= ST_SQR;
      end else begin
        case (state)
          ST_IDLE: ;
          ST_SQR:  state <= ST_SUM;
          ST_SUM: begin
            cnt   <= '0;
            state <= ST_ROOT;
          end
          ST_ROOT: begin
            cnt <= cnt + 6'd1;
            if (cnt == 6'(ROOT_STEPS - 1)) state <= ST_GAP;
          end
          ST_GAP:  state <= ST_MUL;
          ST_MUL: begin
            cnt   <= '0;
            state <= ST_DIV;
          end
          ST_DIV: begin
            cnt <= cnt + 6'd1;
            if (cnt == 6'(DIV_STEPS - 1)) state <= ST_FIN;
          end
          ST_FIN:  state <= ST_IDLE;
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SQR: begin
        sqx <= {16'd0, mag_x} * {16'd0, mag_x};
        sqy <= {16'd0, mag_y} * {16'd0, mag_y};
      end
      ST_SUM: begin
        nrad <= {sqx + sqy, 32'd0};
        rrem <= '0;
        root <= '0;
      end
      ST_ROOT: begin
        rrem <= take ? 33'(rcat - trial) : rcat[32:0];
        root <= {root[30:0], take};
        nrad <= {nrad[61:0], 2'b00};
      end
      ST_GAP: begin
        sq      <= root;
        sq_zero <= (root == 32'd0);
        rolling <= (root <= {1'b0, tq});
        gap     <= (root > {1'b0, tq}) ? root - {1'b0, tq} : 32'd0;
      end
      ST_MUL: begin
        yp   <= prod;
        dq   <= {prod, 6'd0};
        drem <= '0;
      end
      ST_DIV: begin
        drem <= dtake ? 16'(dx - {1'b0, slide}) : dx[15:0];
        dq   <= {dq[50:0], dtake};
      end
      ST_FIN:  cc <= dq[39:0] + {39'd0, (drem != 16'd0)};
      default: ;
    endcase
  end

  always_comb begin
    case (bvp_pkg::reg_idx_t'(paddr[4:2]))
      bvp_pkg::REG_VEL_X:  prdata = {16'd0, vel_x};
      bvp_pkg::REG_VEL_Y:  prdata = {16'd0, vel_y};
      bvp_pkg::REG_SLIDE:  prdata = {16'd0, slide};
      bvp_pkg::REG_ROLL:   prdata = {16'd0, roll};
      bvp_pkg::REG_THRESH: prdata = {17'd0, thresh};
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    cfg.mag     = {mag_y, mag_x};
    cfg.neg     = {vel_y[15], vel_x[15]};
    cfg.slide   = slide;
    cfg.roll    = roll;
    cfg.tq      = tq;
    cfg.sq      = sq;
    cfg.yp      = yp;
    cfg.c       = cc;
    cfg.sq_zero = sq_zero;
    cfg.rolling = rolling;
  end

endmodule

[rtl/bvp_front.sv]
// Front stages: friction products, phase decision and the dividend of the speed drop.
`timescale 1ns / 1ps

module bvp_front (
  input  logic                      clk,
  input  logic [bvp_pkg::F_STG-1:0] en,
  input  logic [23:0]               t,
  input  bvp_pkg::cfg_t             cfg,
  output logic [49:0]               num,
  output logic [31:0]               base
);

  logic [23:0] t0;
  logic [39:0] ms0, mr0, ms1, mr1, e1, pel2;
  logic        slid1, post2;
  logic [31:0] peh2, base2;
  logic [49:0] nrs2;
  logic [55:0] pe;

  assign pe = {16'd0, pel2} + {peh2, 24'd0};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0  <= t;
      ms0 <= {24'd0, cfg.slide} * {16'd0, t};
      mr0 <= {24'd0, cfg.roll} * {16'd0, t};
    end
    if (en[1]) begin
      ms1   <= ms0;
      mr1   <= mr0;
      // leftover time past the slide, valid only once sliding has ended
      e1    <= {t0, 16'd0} - cfg.c;
      slid1 <= ({ms0, 10'd0} < {4'd0, cfg.yp});
    end
    if (en[2]) begin
      pel2  <= {24'd0, cfg.roll} * {16'd0, e1[23:0]};
      peh2  <= {16'd0, cfg.roll} * {16'd0, e1[39:24]};
      post2 <= !cfg.rolling && !slid1;
      nrs2  <= {cfg.rolling ? mr1 : ms1, 10'd0};
      base2 <= (!cfg.rolling && !slid1) ? {1'b0, cfg.tq} : cfg.sq;
    end
    if (en[3]) begin
      num  <= post2 ? pe[55:6] : nrs2;
      base <= base2;
    end
  end

endmodule

[rtl/bvp_cdiv.sv]
// Pipelined divide by 15625 of the speed-drop dividend, four quotient bits a stage.
`timescale 1ns / 1ps

module bvp_cdiv (
  input  logic                      clk,
  input  logic [bvp_pkg::C_STG-1:0] en,
  input  logic [49:0]               num,
  input  logic [31:0]               base,
  output logic [31:0]               q,
  output logic [31:0]               base_o,
  output logic                      sat_o
);

  logic [13:0] rr [bvp_pkg::C_STG];
  logic [31:0] nn [bvp_pkg::C_STG];
  logic [31:0] qq [bvp_pkg::C_STG];
  logic [31:0] bs [bvp_pkg::C_STG];
  logic        st [bvp_pkg::C_STG];

  for (genvar g = 0; g < bvp_pkg::C_STG; g++) begin : g_stg
    logic [13:0] r_in, r_nx;
    logic [31:0] n_in, n_nx, q_in, q_nx, b_in;
    logic        s_in;

    if (g == 0) begin : g_head
      // a quotient of 2^32 or more exceeds any base: saturate instead
      assign r_in = num[45:32];
      assign n_in = num[31:0];
      assign q_in = '0;
      assign b_in = base;
      assign s_in = (num[49:32] >= {3'd0, bvp_pkg::DROP_DIV});
    end else begin : g_body
      assign r_in = rr[g-1];
      assign n_in = nn[g-1];
      assign q_in = qq[g-1];
      assign b_in = bs[g-1];
      assign s_in = st[g-1];
    end

    always_comb begin
      logic [14:0] sr;
      r_nx = r_in;
      n_nx = n_in;
      q_nx = q_in;
      for (int i = 0; i < bvp_pkg::C_BITS; i++) begin
        sr   = bvp_pkg::cdiv_step(r_nx, n_nx[31]);
        r_nx = sr[13:0];
        q_nx = {q_nx[30:0], sr[14]};
        n_nx = {n_nx[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        rr[g] <= r_nx;
        nn[g] <= n_nx;
        qq[g] <= q_nx;
        bs[g] <= b_in;
        st[g] <= s_in;
      end
    end
  end

  assign q      = qq[bvp_pkg::C_STG-1];
  assign base_o = bs[bvp_pkg::C_STG-1];
  assign sat_o  = st[bvp_pkg::C_STG-1];

endmodule

[rtl/bvp_scale.sv]
// Back stages: remaining speed, component scaling by remaining/initial speed, sign.
`timescale 1ns / 1ps

module bvp_scale (
  input  logic                      clk,
  input  logic [bvp_pkg::S_LEN-1:0] en,
  input  logic [31:0]               q,
  input  logic [31:0]               base,
  input  logic                      sat,
  input  bvp_pkg::cfg_t             cfg,
  output logic [15:0]               out_x,
  output logic [15:0]               out_y
);

  localparam int DIV0 = 2;
  localparam int OUTS = bvp_pkg::S_LEN - 1;

  logic [31:0]      rem;
  logic [1:0][47:0] prod;
  logic [1:0][31:0] dr [bvp_pkg::S_DIV];
  logic [1:0][15:0] dn [bvp_pkg::S_DIV];
  logic [1:0][15:0] dq [bvp_pkg::S_DIV];
  logic [1:0][15:0] mag;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem <= (sat || q >= base) ? 32'd0 : base - q;
    end
    if (en[1]) begin
      for (int l = 0; l < 2; l++) begin
        prod[l] <= {32'd0, cfg.mag[l]} * {16'd0, rem};
      end
    end
  end

  for (genvar g = 0; g < bvp_pkg::S_DIV; g++) begin : g_stg
    logic [1:0][31:0] r_in, r_nx;
    logic [1:0][15:0] n_in, n_nx, q_in, q_nx;

    if (g == 0) begin : g_head
      // rem <= sq keeps the high part below the divisor
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign r_in[l] = prod[l][47:16];
        assign n_in[l] = prod[l][15:0];
        assign q_in[l] = '0;
      end
    end else begin : g_body
      assign r_in = dr[g-1];
      assign n_in = dn[g-1];
      assign q_in = dq[g-1];
    end

    always_comb begin
      logic [32:0] sr;
      r_nx = r_in;
      n_nx = n_in;
      q_nx = q_in;
      for (int l = 0; l < 2; l++) begin
        for (int i = 0; i < bvp_pkg::S_BITS; i++) begin
          sr      = bvp_pkg::sdiv_step(r_nx[l], n_nx[l][15], cfg.sq);
          r_nx[l] = sr[31:0];
          q_nx[l] = {q_nx[l][14:0], sr[32]};
          n_nx[l] = {n_nx[l][14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[DIV0+g]) begin
        dr[g] <= r_nx;
        dn[g] <= n_nx;
        dq[g] <= q_nx;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l] = dq[bvp_pkg::S_DIV-1][l];
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUTS]) begin
      out_x <= cfg.sq_zero ? 16'd0 : (cfg.neg[0] ? 16'(16'd0 - mag[0]) : mag[0]);
      out_y <= cfg.sq_zero ? 16'd0 : (cfg.neg[1] ? 16'(16'd0 - mag[1]) : mag[1]);
    end
  end

endmodule

[rtl/ball_velocity_predictor.sv]
// Top level of the ball velocity predictor: stream ports, register port, pipeline control.
`timescale 1ns / 1ps

// Each request carries a look-ahead time in microseconds and yields one predicted
// velocity (x, y in mm/s); a new request can enter every cycle outside setup and
// stalls; a stalled output only holds the stages that are full, bubbles ahead of
// it still close up. The initial speed and the slide-to-roll time offset depend on
// the registers alone and are worked out by a setup sequencer: after reset and
// after every register write s_tready stays low through a 32-step square root,
// then a 52-step divide by the sliding deceleration. Registers are 32-bit words at
// byte addresses 0 (init_vel_x), 4 (init_vel_y), 8 (slide_decel), 12 (roll_decel)
// and 16 (roll_threshold); write them only while no request is in flight.

module ball_velocity_predictor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] lookahead_us
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] pred_vel_x, [31:16] pred_vel_y
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bvp_pkg::cfg_t             cfg;
  logic                      busy;
  logic [bvp_pkg::NSTG-1:0]  vld;
  logic [bvp_pkg::NSTG:0]    en;
  logic [49:0]               num;
  logic [31:0]               base, cq, cbase;
  logic                      csat;
  logic [15:0]               out_x, out_y;

  assign pready = 1'b1;

  // a stage moves when it is empty or the one after it moves
  assign en[bvp_pkg::NSTG] = m_tready;
  for (genvar k = 0; k < bvp_pkg::NSTG; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign s_tready = en[0] && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid && !busy;
      for (int k = 1; k < bvp_pkg::NSTG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  bvp_setup u_setup (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .busy    (busy)
  );

  bvp_front u_front (
    .clk  (clk),
    .en   (en[bvp_pkg::F_STG-1:0]),
    .t    (s_tdata),
    .cfg  (cfg),
    .num  (num),
    .base (base)
  );

  bvp_cdiv u_cdiv (
    .clk    (clk),
    .en     (en[bvp_pkg::C_FIRST +: bvp_pkg::C_STG]),
    .num    (num),
    .base   (base),
    .q      (cq),
    .base_o (cbase),
    .sat_o  (csat)
  );

  bvp_scale u_scale (
    .clk   (clk),
    .en    (en[bvp_pkg::S_FIRST +: bvp_pkg::S_LEN]),
    .q     (cq),
    .base  (cbase),
    .sat   (csat),
    .cfg   (cfg),
    .out_x (out_x),
    .out_y (out_y)
  );

  assign m_tvalid = vld[bvp_pkg::NSTG-1];
  assign m_tdata  = {out_y, out_x};

endmodule

[rtl/bvp_chk.sv]
// Port-level checks of the ball velocity predictor, bound to the top level.
`timescale 1ns / 1ps

module bvp_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // a register write restarts setup, so requests are refused right after
  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> !s_tready)
    else $error("request taken during setup after a write");

  // setup also runs after reset
  a_rst_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_tready)
    else $error("request taken right after reset");

endmodule

bind ball_velocity_predictor bvp_chk u_chk (.*);

[sim/testbench.sv]
// Testbench of the ball velocity predictor: directed table plus random phases, checked by a predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int PIPE_WAIT = 40;    // cycles let pass after the last result
  localparam int DOG_LIMIT = 4000;  // cycles with no handshake before giving up
  localparam int RAND_PHASES = 13;
  localparam int RAND_ITEMS = 100;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } vel_t;

  typedef struct {
    bit          is_cfg;
    logic [15:0] vx, vy, slide, roll;
    logic [14:0] thr;
    logic [23:0] t;
    bit          typed;
    vel_t        exp_vel;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [23:0] lookahead_us
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [15:0] pred_vel_x, [31:16] pred_vel_y
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // register copy used by the predictor
  logic [15:0] cur_vx = '0, cur_vy = '0, cur_slide = '0, cur_roll = '0;
  logic [14:0] cur_thr = '0;

  vel_t pending_vel[$];
  int   errors = 0;
  int   requests = 0;
  int   results = 0;
  int   cfg_writes = 0;
  int   idle_cycles = 0;
  int   stall_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;

  ball_velocity_predictor u_dut (.*);

  always #1 clk = ~clk;

  function automatic logic [63:0] speed_root(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] scale_part(input logic [15:0] v, input logic [63:0] rem,
                                             input logic [63:0] sq);
    logic [63:0] mag, q;
    mag = v[15] ? 64'(-$signed({{48{v[15]}}, v})) : 64'(v);
    q = (mag * rem) / sq;
    return v[15] ? 16'(-q) : q[15:0];
  endfunction

  function automatic vel_t predict_vel(input logic [23:0] t);
    logic [63:0] ax, ay, sq, tq, rem, sd, d, e, rd;
    vel_t r;
    ax = cur_vx[15] ? 64'(-$signed({{48{1'b1}}, cur_vx})) : 64'(cur_vx);
    ay = cur_vy[15] ? 64'(-$signed({{48{1'b1}}, cur_vy})) : 64'(cur_vy);
    sq = speed_root((ax * ax + ay * ay) << 32);
    tq = 64'(cur_thr) << 16;
    if (sq == 0) return '0;
    if (sq > tq) begin
      if (cur_slide == 0) begin
        rem = sq;
      end else begin
        sd = (64'(cur_slide) * t * 65536) / 1000000;
        if (sq - sd > tq && sd < sq) begin
          rem = sq - sd;
        end else if (cur_roll == 0) begin
          rem = tq;
        end else begin
          // time left after the ball reaches the threshold, scaled
          d = 64'(cur_slide) * t * 65536 - (sq - tq) * 1000000;
          e = d / cur_slide;
          rd = (64'(cur_roll) * e) / 1000000;
          rem = rd >= tq ? 0 : tq - rd;
        end
      end
    end else if (cur_roll == 0) begin
      rem = sq;
    end else begin
      rd = (64'(cur_roll) * t * 65536) / 1000000;
      rem = rd >= sq ? 0 : sq - rd;
    end
    r.vx = scale_part(cur_vx, rem, sq);
    r.vy = scale_part(cur_vy, rem, sq);
    return r;
  endfunction

  task automatic reg_write(input bvp_pkg::reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= {16'(0), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bvp_pkg::REG_VEL_X:  cur_vx = val;
      bvp_pkg::REG_VEL_Y:  cur_vy = val;
      bvp_pkg::REG_SLIDE:  cur_slide = val;
      bvp_pkg::REG_ROLL:   cur_roll = val;
      bvp_pkg::REG_THRESH: cur_thr = val[14:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_motion(input logic [15:0] vx, vy, slide, roll, input logic [14:0] thr);
    wait (pending_vel.size() == 0);
    repeat (PIPE_WAIT) @(posedge clk);
    reg_write(bvp_pkg::REG_VEL_X, vx);
    reg_write(bvp_pkg::REG_VEL_Y, vy);
    reg_write(bvp_pkg::REG_SLIDE, slide);
    reg_write(bvp_pkg::REG_ROLL, roll);
    reg_write(bvp_pkg::REG_THRESH, {1'b0, thr});
  endtask

  // holds the request until accepted; the expectation is queued at the accepting edge
  task automatic send_request(input logic [23:0] t, input bit typed, input vel_t typed_vel);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= t;
    do @(posedge clk); while (!s_tready);
    pending_vel.push_back(typed ? typed_vel : predict_vel(t));
    requests++;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic row_t cfg_row(input logic [15:0] vx, vy, slide, roll,
                                   input logic [14:0] thr);
    row_t r;
    r = '{is_cfg: 1, vx: vx, vy: vy, slide: slide, roll: roll, thr: thr,
          t: 0, typed: 0, exp_vel: '0};
    return r;
  endfunction

  function automatic row_t req_row(input logic [23:0] t, input bit typed,
                                   input logic [15:0] ex, ey);
    row_t r;
    r = '{is_cfg: 0, vx: 0, vy: 0, slide: 0, roll: 0, thr: 0,
          t: t, typed: typed, exp_vel: '{ex, ey}};
    return r;
  endfunction

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic logic [15:0] rand_decel();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1, 2: return 16'($urandom);
      default: return 16'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic logic [23:0] rand_time();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 65535));
      default: return 24'($urandom_range(0, 3000000));
    endcase
  endfunction

  // output side: stall pattern switches between none, light and heavy
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      vel_t got;
      got.vx = m_tdata[15:0];
      got.vy = m_tdata[31:16];
      results++;
      if (pending_vel.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result x=%0d y=%0d", got.vx, got.vy);
      end else begin
        vel_t want;
        want = pending_vel.pop_front();
        if (got.vx !== want.vx || got.vy !== want.vy) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                     results, want.vx, want.vy, got.vx, got.vy);
        end
      end
    end
    if (mode_left == 0) begin
      mode_left <= $urandom_range(50, 300);
      stall_mode <= $urandom_range(0, 2);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (stall_mode != 0 && $urandom_range(0, 7) < stall_mode * 2) begin
      stall_left <= $urandom_range(0, stall_mode * 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= DOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    row_t plan[$];
    logic [14:0] thr;
    logic [15:0] vx, vy;
    plan.push_back(req_row(24'd0, 1, 16'd0, 16'd0));
    plan.push_back(req_row(24'hFFFFFF, 1, 16'd0, 16'd0));
    // no sliding deceleration: speed never drops
    plan.push_back(cfg_row(16'd3000, -16'sd4000, 16'd0, 16'd0, 15'd0));
    plan.push_back(req_row(24'd0, 1, 16'd3000, -16'sd4000));
    plan.push_back(req_row(24'hFFFFFF, 1, 16'd3000, -16'sd4000));
    // rolling from the start with no rolling deceleration
    plan.push_back(cfg_row(16'd3000, -16'sd4000, 16'd1000, 16'd0, 15'h7FFF));
    plan.push_back(req_row(24'hFFFFFF, 1, 16'd3000, -16'sd4000));
    // speed exactly at the threshold counts as rolling
    plan.push_back(cfg_row(16'd3000, 16'd4000, 16'd1000, 16'd2000, 15'd5000));
    plan.push_back(req_row(24'd1000000, 1, 16'd1800, 16'd2400));
    plan.push_back(req_row(24'd0, 0, 0, 0));
    plan.push_back(cfg_row(-16'sd20000, 16'd20000, 16'hFFFF, 16'hFFFF, 15'd1000));
    plan.push_back(req_row(24'd0, 0, 0, 0));
    plan.push_back(req_row(24'd100000, 0, 0, 0));
    plan.push_back(req_row(24'd430000, 0, 0, 0));
    plan.push_back(req_row(24'hFFFFFF, 1, 16'd0, 16'd0));
    // register values beyond the documented range
    plan.push_back(cfg_row(16'h7FFF, 16'h8000, 16'hFFFF, 16'd1, 15'd0));
    plan.push_back(req_row(24'd1, 0, 0, 0));
    plan.push_back(req_row(24'hFFFFFF, 0, 0, 0));
    plan.push_back(cfg_row(16'h8000, 16'd0, 16'd1, 16'hFFFF, 15'd30000));
    plan.push_back(req_row(24'd12345, 0, 0, 0));
    plan.push_back(req_row(24'hFFFFFF, 0, 0, 0));
    plan.push_back(cfg_row(16'd5, -16'sd1, 16'd7, 16'd3, 15'd2));
    plan.push_back(req_row(24'h555555, 0, 0, 0));
    plan.push_back(req_row(24'hAAAAAA, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        s_tvalid <= 1'b0;
        set_motion(plan[i].vx, plan[i].vy, plan[i].slide, plan[i].roll, plan[i].thr);
      end else begin
        send_request(plan[i].t, plan[i].typed, plan[i].exp_vel);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      vx = rand_vel();
      vy = rand_vel();
      if ($urandom_range(0, 7) == 0) thr = 15'($urandom);
      else if ($urandom_range(0, 2) == 0) thr = 15'(vx[15] ? -vx : vx);
      else thr = 15'($urandom_range(0, 30000));
      s_tvalid <= 1'b0;
      set_motion(vx, vy, rand_decel(), rand_decel(), thr);
      for (int k = 0; k < RAND_ITEMS; k++) send_request(rand_time(), 0, '0);
    end
    s_tvalid <= 1'b0;

    wait (pending_vel.size() == 0);
    repeat (PIPE_WAIT) @(posedge clk);
    $display("%0d requests checked over %0d register writes, directed cases and %0d random",
             requests, cfg_writes, RAND_PHASES);
    $display("motion settings; %0d mismatches", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
